FILE: hw/rtl/nearest_palette_color_match_core_defines.svh
// Assertion macros used by the checker of the palette match core.
// Depends on nothing; include by bare file name.
`ifndef NEAREST_PALETTE_COLOR_MATCH_CORE_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_MATCH_CORE_DEFINES_SVH

// Same-cycle implication, reset-qualified (active-low reset).
`define NPCM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("npcm port check failed");

// Next-cycle implication, reset-qualified (active-low reset).
`define NPCM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("npcm port check failed");

`endif

FILE: hw/rtl/npcm_pkg.sv
// Shared constants, types and helpers for the nearest palette colour match core.
// No dependencies.
`default_nettype none

package npcm_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int IDX_W         = $clog2(PALETTE_DEPTH);
    localparam int COLOR_W       = 24;
    localparam int CHAN_W        = 8;
    localparam int SQ_W          = 2 * CHAN_W;
    localparam int DIST_W        = 18;
    localparam int CFG_W         = 9;
    localparam int MATCH_W       = 8;

    localparam logic [DIST_W-1:0] DIST_START = DIST_W'(256 * 256 * 3);
    localparam logic [CFG_W-1:0]  CFG_RESET  = CFG_W'(2);

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DRAIN,
        S_DONE
    } t_state;

    // Tag that travels with each palette read through the pipeline.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
    } t_tag;

    // Result of the shared distance unit for one palette entry.
    typedef struct packed {
        logic             valid;
        logic             last;
        logic [IDX_W-1:0] idx;
        logic             eq;
        logic [SQ_W-1:0]  sq_r;
        logic [SQ_W-1:0]  sq_g;
        logic [SQ_W-1:0]  sq_b;
    } t_dist;

    // Clamp the entry count to [2, PALETTE_DEPTH] and return the final index.
    function automatic logic [IDX_W-1:0] last_index(input logic [CFG_W-1:0] n);
        int k;
        k = int'(n);
        if (k < 2) begin
            k = 2;
        end
        if (k > PALETTE_DEPTH) begin
            k = PALETTE_DEPTH;
        end
        return IDX_W'(k - 1);
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/nearest_palette_color_match_core.sv
// Nearest palette colour match core. A write word (operation = 1) stores a
// colour in the palette; busy stays low. A lookup word
// (operation = 0) scans entries 0 to n-1, n being entries_in_use held within
// 2..256, one entry per cycle through the single palette read port and the
// shared distance unit; busy stays high until the result appears on the
// last busy cycle with o_strobe high for exactly one cycle. The receiver
// cannot stall, so sample the result on the strobe. Lowest exact match wins,
// else the nearest entry from index 1 up, lowest index on a tie. Reading a
// palette entry that was never written gives an undefined result.
// Depends on npcm_pkg, npcm_palette_ram, npcm_dist_unit.
`default_nettype none

module nearest_palette_color_match_core (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic                             i_operation,
    input  wire logic [npcm_pkg::COLOR_W-1:0]     i_color,
    input  wire logic [7:0]                       i_entry_index,
    input  wire logic                             i_cfg_we,
    input  wire logic [npcm_pkg::CFG_W-1:0]       i_cfg_wdata,
    output logic                                  o_strobe,
    output logic [npcm_pkg::MATCH_W-1:0]          o_match_index,
    output logic                                  o_exact_hit
);

    npcm_pkg::t_state                  r_state, n_state;
    logic [npcm_pkg::IDX_W-1:0]        r_addr, n_addr;
    logic [npcm_pkg::CFG_W-1:0]        r_cfg;
    logic [npcm_pkg::COLOR_W-1:0]      r_color;
    logic [npcm_pkg::IDX_W-1:0]        r_best;
    logic [npcm_pkg::DIST_W-1:0]       r_dmin;
    logic                              r_exact;
    logic [npcm_pkg::IDX_W-1:0]        r_exact_idx;
    npcm_pkg::t_tag                    r_tag1;
    npcm_pkg::t_tag                    tag0;
    npcm_pkg::t_dist                   unit_out;
    logic [npcm_pkg::COLOR_W-1:0]      rd_data;
    logic [npcm_pkg::IDX_W-1:0]        last_idx;
    logic [npcm_pkg::DIST_W-1:0]       sum;
    logic                              accept;
    logic                              wr_en;

    assign accept   = start && !busy;
    assign wr_en    = accept && (i_operation == npcm_pkg::OP_WRITE)
                      && (int'(i_entry_index) < npcm_pkg::PALETTE_DEPTH);
    assign last_idx = npcm_pkg::last_index(r_cfg);

    npcm_palette_ram #(
        .DEPTH (npcm_pkg::PALETTE_DEPTH),
        .WIDTH (npcm_pkg::COLOR_W)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (npcm_pkg::IDX_W'(i_entry_index)),
        .i_wdata (i_color),
        .i_raddr (r_addr),
        .o_rdata (rd_data)
    );

    npcm_dist_unit u_dist (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_color (r_color),
        .i_entry (rd_data),
        .i_tag   (r_tag1),
        .o_dist  (unit_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npcm_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_addr    = r_addr;
        tag0      = '0;
        busy      = 1'b1;
        o_strobe  = 1'b0;
        case (r_state)
            npcm_pkg::S_IDLE: begin
                busy = 1'b0;
                if (accept && (i_operation == npcm_pkg::OP_LOOKUP)) begin
                    n_state = npcm_pkg::S_SCAN;
                    n_addr  = '0;
                end
            end
            npcm_pkg::S_SCAN: begin
                tag0.valid = 1'b1;
                tag0.idx   = r_addr;
                tag0.last  = (r_addr == last_idx);
                if (r_addr == last_idx) begin
                    n_state = npcm_pkg::S_DRAIN;
                end else begin
                    n_addr = r_addr + 1'b1;
                end
            end
            npcm_pkg::S_DRAIN: begin
                // hold until the final entry leaves the compare stage
                if (unit_out.valid && unit_out.last) begin
                    n_state = npcm_pkg::S_DONE;
                end
            end
            npcm_pkg::S_DONE: begin
                o_strobe = 1'b1;
                n_state  = npcm_pkg::S_IDLE;
            end
            default: begin
                n_state = npcm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_tag1.idx <= tag0.idx;
        if (!i_rst_n) begin
            r_cfg        <= npcm_pkg::CFG_RESET;
            r_tag1.valid <= 1'b0;
            r_tag1.last  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            r_tag1.valid <= tag0.valid;
            r_tag1.last  <= tag0.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
    end

    assign sum = npcm_pkg::DIST_W'(unit_out.sq_r) + npcm_pkg::DIST_W'(unit_out.sq_g)
               + npcm_pkg::DIST_W'(unit_out.sq_b);

    // Search registers: first exact hit sticks, strict less-than keeps the lowest index.
    always_ff @(posedge i_clk) begin
        if (accept && (i_operation == npcm_pkg::OP_LOOKUP)) begin
            r_color     <= i_color;
            r_best      <= npcm_pkg::IDX_W'(1);
            r_dmin      <= npcm_pkg::DIST_START;
            r_exact     <= 1'b0;
            r_exact_idx <= '0;
        end else if (unit_out.valid) begin
            if (!r_exact && unit_out.eq) begin
                r_exact     <= 1'b1;
                r_exact_idx <= unit_out.idx;
            end
            if ((unit_out.idx != '0) && (sum < r_dmin)) begin
                r_dmin <= sum;
                r_best <= unit_out.idx;
            end
        end
    end

    assign o_exact_hit   = r_exact;
    assign o_match_index = npcm_pkg::MATCH_W'(r_exact ? r_exact_idx : r_best);

endmodule

`default_nettype wire

FILE: hw/rtl/npcm_palette_ram.sv
// Single write port, single registered read port palette memory.
// Generic; no package dependency.
`default_nettype none

module npcm_palette_ram #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 24
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hw/rtl/npcm_dist_unit.sv
// Shared distance unit: per-channel squared differences and exact compare, registered.
// Depends on npcm_pkg.
`default_nettype none

module npcm_dist_unit (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [npcm_pkg::COLOR_W-1:0]  i_color,
    input  wire logic [npcm_pkg::COLOR_W-1:0]  i_entry,
    input  wire npcm_pkg::t_tag                i_tag,
    output npcm_pkg::t_dist                    o_dist
);

    logic [npcm_pkg::CHAN_W-1:0] d_r;
    logic [npcm_pkg::CHAN_W-1:0] d_g;
    logic [npcm_pkg::CHAN_W-1:0] d_b;

    function automatic logic [npcm_pkg::CHAN_W-1:0] abs_diff(
        input logic [npcm_pkg::CHAN_W-1:0] a,
        input logic [npcm_pkg::CHAN_W-1:0] b
    );
        return (a > b) ? (a - b) : (b - a);
    endfunction

    always_comb begin
        d_r = abs_diff(i_color[23:16], i_entry[23:16]);
        d_g = abs_diff(i_color[15:8],  i_entry[15:8]);
        d_b = abs_diff(i_color[7:0],   i_entry[7:0]);
    end

    always_ff @(posedge i_clk) begin
        o_dist.idx  <= i_tag.idx;
        o_dist.eq   <= (i_entry == i_color);
        o_dist.sq_r <= npcm_pkg::SQ_W'(d_r) * npcm_pkg::SQ_W'(d_r);
        o_dist.sq_g <= npcm_pkg::SQ_W'(d_g) * npcm_pkg::SQ_W'(d_g);
        o_dist.sq_b <= npcm_pkg::SQ_W'(d_b) * npcm_pkg::SQ_W'(d_b);
        if (!i_rst_n) begin
            o_dist.valid <= 1'b0;
            o_dist.last  <= 1'b0;
        end else begin
            o_dist.valid <= i_tag.valid;
            o_dist.last  <= i_tag.last;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/npcm_checker.sv
// Port-level checks for the palette match core, attached by bind.
// Depends on nearest_palette_color_match_core_defines.svh.
`default_nettype none

`include "nearest_palette_color_match_core_defines.svh"

module npcm_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic start,
    input wire logic busy,
    input wire logic i_operation,
    input wire logic o_strobe
);

    // A result only closes a lookup in progress.
    `NPCM_ASSERT_IMP(a_strobe_busy, i_clk, i_rst_n, o_strobe, busy)

    // The strobe cycle is the last busy one.
    `NPCM_ASSERT_NXT(a_strobe_then_idle, i_clk, i_rst_n, o_strobe, !busy && !o_strobe)

    // An accepted lookup word raises busy.
    `NPCM_ASSERT_NXT(a_lookup_busy, i_clk, i_rst_n, start && !busy && !i_operation, busy)

    // A write word completes at once with no result.
    `NPCM_ASSERT_NXT(a_write_quiet, i_clk, i_rst_n, start && !busy && i_operation,
        !busy && !o_strobe)

endmodule

bind nearest_palette_color_match_core npcm_checker u_npcm_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_operation (i_operation),
    .o_strobe    (o_strobe)
);

`default_nettype wire
